@@ sv/sclu_pkg.sv @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform source: shared definitions
// Generator constants, output packing widths and the constant-modulus
// reduction helpers that fold a product back below each modulus.
// ----------------------------------------------------------------------------
package sclu_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARM_EXTRA      = 7;

    localparam logic [30:0] MOD_ONE  = 31'd2147483563;
    localparam logic [30:0] MOD_TWO  = 31'd2147483399;
    localparam logic [30:0] DRAW_TOP = 31'd2147483562;
    localparam logic [31:0] MUL_ONE  = 32'd40014;
    localparam logic [31:0] MUL_TWO  = 32'd40692;

    // Each modulus is two to the 31 minus a small offset.
    localparam logic [7:0] OFS_ONE = 8'd85;
    localparam logic [7:0] OFS_TWO = 8'd249;

    localparam logic [31:0] FRAC_CAP = 32'hFFFF_FE00;

    localparam int IN_W  = 64;
    localparam int OUT_W = 64;

    // x mod MOD_ONE for a product of a 31-bit value and a 16-bit multiplier.
    function automatic logic [30:0] reduce_one(input logic [46:0] p);
        logic [31:0] t;
        t = 32'(p[30:0]) + 32'(p[46:31]) * 32'(OFS_ONE);
        if (t >= 32'(MOD_ONE))
        begin
            t = t - 32'(MOD_ONE);
        end
        return t[30:0];
    endfunction

    // x mod MOD_TWO for a product of a 31-bit value and a 16-bit multiplier.
    function automatic logic [30:0] reduce_two(input logic [46:0] p);
        logic [31:0] t;
        t = 32'(p[30:0]) + 32'(p[46:31]) * 32'(OFS_TWO);
        if (t >= 32'(MOD_TWO))
        begin
            t = t - 32'(MOD_TWO);
        end
        return t[30:0];
    endfunction

    // floor(draw * 2^32 / MOD_ONE), capped just below one. Since
    // 2^32 = 2 * MOD_ONE + 170, the quotient is 2 * draw plus a small term.
    function automatic logic [31:0] draw_fraction(input logic [30:0] draw);
        logic [38:0] t;
        logic [31:0] r;
        logic [31:0] q;
        logic [31:0] f;
        t = 39'(draw) * 39'd170;
        r = 32'(t[30:0]) + 32'(t[38:31]) * 32'(OFS_ONE);
        q = 32'(t[38:31]) + ((r >= 32'(MOD_ONE)) ? 32'd1 : 32'd0);
        f = {draw, 1'b0} + q;
        if (f > FRAC_CAP)
        begin
            f = FRAC_CAP;
        end
        return f;
    endfunction

endpackage

@@ sv/shuffled_combined_lcg_uniform_unit.sv @@
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform unit
// Two combined multiplicative congruential generators with a shuffle table,
// scaling each draw into a requested signed Q16.16 interval.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on s_axis carries range_min and range_max. Each request
// yields one result beat on m_axis with the scaled value and the raw draw.
// The cfg channel writes the seed magnitude; it is always ready and the seed
// only matters for the table warm-up that the first request after reset runs.
// All arithmetic goes through one 32x32 multiplier under a small sequencer,
// so the unit holds one request at a time and s_axis_tready is low meanwhile.
// A request steps through ST_G1, ST_G2, ST_SLOT, ST_READ, ST_DRAW, ST_FRAC,
// ST_SCALE and ST_OUT, and a new one is taken only after its result has
// moved to the output register. The first request after reset runs a warm-up
// first, with a multiply state and a reduce state for each generator step.
// Reset clears the sequencer, the generators and the warm-up flag; the table
// is rebuilt by the next warm-up. A finished result waits in the output
// register while m_axis is stalled; a request may still be accepted then,
// and its own result is held back until the register is taken.
// ----------------------------------------------------------------------------
module shuffled_combined_lcg_uniform_unit #(
    parameter int TABLE_DEPTH = sclu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] range_min, [63:32] range_max
    input  logic [sclu_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [31:0] scaled_value, [62:32] raw_draw, [63] zero
    output logic [sclu_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [30:0]                cfg_data
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WARM_N  = TABLE_DEPTH + sclu_pkg::WARM_EXTRA;
    localparam int CNT_W   = $clog2(WARM_N + 1);
    localparam longint SLOT_DIV = 64'd1 + 64'(sclu_pkg::DRAW_TOP) / 64'(TABLE_DEPTH);
    localparam int SLOT_L  = $clog2(SLOT_DIV);
    localparam int SLOT_SH = 31 + SLOT_L;
    // Rounded-up reciprocal: exact floor division for every 31-bit dividend.
    localparam longint SLOT_RECIP_L = ((64'd1 << SLOT_SH) + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam logic [31:0] SLOT_RECIP = SLOT_RECIP_L[31:0];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_G1,
        ST_G2,
        ST_SLOT,
        ST_READ,
        ST_DRAW,
        ST_FRAC,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic                       warmed_reg;
    logic [30:0]                seed_reg;
    logic [30:0]                g1_reg;
    logic [30:0]                g2_reg;
    logic [30:0]                last_draw_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [31:0]                lo_reg;
    logic [31:0]                hi_reg;
    logic [31:0]                mag_reg;
    logic                       neg_reg;
    logic [31:0]                frac_reg;
    logic [63:0]                prod_reg;
    logic                       out_valid_reg;
    logic [sclu_pkg::OUT_W-1:0] out_data_reg;

    logic [30:0]                shuf_mem [TABLE_DEPTH];
    logic [30:0]                entry_reg;

    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [30:0]                g1_next;
    logic [30:0]                g2_next;
    logic [30:0]                seed_clamped;
    logic [63:0]                slot_wide;
    logic [IDX_W-1:0]           slot;
    logic [30:0]                draw_next;
    logic signed [32:0]         span;
    logic [32:0]                span_abs;
    logic signed [33:0]         res_wide;
    logic [31:0]                res_sat;
    logic                       tbl_we;
    logic [IDX_W-1:0]           tbl_waddr;
    logic [30:0]                tbl_wdata;
    logic                       out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            ST_WARM_MUL, ST_G1:
            begin
                mul_a = {1'b0, g1_reg};
                mul_b = sclu_pkg::MUL_ONE;
            end
            ST_G2:
            begin
                mul_a = {1'b0, g2_reg};
                mul_b = sclu_pkg::MUL_TWO;
            end
            ST_SLOT:
            begin
                mul_a = {1'b0, last_draw_reg};
                mul_b = SLOT_RECIP;
            end
            ST_SCALE:
            begin
                mul_a = mag_reg;
                mul_b = frac_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign g1_next = sclu_pkg::reduce_one(prod_reg[46:0]);
    assign g2_next = sclu_pkg::reduce_two(prod_reg[46:0]);

    always_comb
    begin
        if (seed_reg == 31'd0)
        begin
            seed_clamped = 31'd1;
        end
        else if (seed_reg > sclu_pkg::DRAW_TOP)
        begin
            seed_clamped = sclu_pkg::DRAW_TOP;
        end
        else
        begin
            seed_clamped = seed_reg;
        end
    end

    assign slot_wide = prod_reg >> SLOT_SH;
    assign slot = (slot_wide >= 64'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                  : slot_wide[IDX_W-1:0];

    always_comb
    begin
        logic [31:0] d;
        if (entry_reg > g2_reg)
        begin
            d = 32'(entry_reg) - 32'(g2_reg);
        end
        else
        begin
            d = 32'(entry_reg) + 32'(sclu_pkg::DRAW_TOP) - 32'(g2_reg);
        end
        draw_next = d[30:0];
    end

    assign span     = $signed({hi_reg[31], hi_reg}) - $signed({lo_reg[31], lo_reg});
    assign span_abs = span[32] ? 33'(-span) : 33'(span);

    // The sum always lies between the range ends; saturation is a guard.
    assign res_wide = neg_reg ? ($signed({{2{lo_reg[31]}}, lo_reg})
                                 - $signed({2'b00, prod_reg[63:32]}))
                              : ($signed({{2{lo_reg[31]}}, lo_reg})
                                 + $signed({2'b00, prod_reg[63:32]}));

    always_comb
    begin
        if (res_wide > 34'sd2147483647)
        begin
            res_sat = 32'h7FFF_FFFF;
        end
        else if (res_wide < -34'sd2147483648)
        begin
            res_sat = 32'h8000_0000;
        end
        else
        begin
            res_sat = res_wide[31:0];
        end
    end

    assign tbl_we    = ((state_reg == ST_WARM_RED) && (cnt_reg < CNT_W'(TABLE_DEPTH)))
                       || (state_reg == ST_READ);
    assign tbl_waddr = (state_reg == ST_READ) ? slot : cnt_reg[IDX_W-1:0];
    assign tbl_wdata = (state_reg == ST_READ) ? g1_reg : g1_next;

    assign out_free = !out_valid_reg || m_axis_tready;

    // Shuffle table: the read returns the entry before this cycle's write.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            shuf_mem[tbl_waddr] <= tbl_wdata;
        end
        if (state_reg == ST_READ)
        begin
            entry_reg <= shuf_mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            warmed_reg    <= 1'b0;
            seed_reg      <= 31'd1;
            g1_reg        <= 31'd0;
            g2_reg        <= 31'd0;
            last_draw_reg <= 31'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Hold the product until the output register is free.
            if (state_reg != ST_OUT)
            begin
                prod_reg <= mul_a * mul_b;
            end

            if (cfg_valid)
            begin
                seed_reg <= cfg_data;
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        lo_reg <= s_axis_tdata[31:0];
                        hi_reg <= s_axis_tdata[63:32];
                        if (warmed_reg)
                        begin
                            state_reg <= ST_G1;
                        end
                        else
                        begin
                            g1_reg    <= seed_clamped;
                            g2_reg    <= seed_clamped;
                            cnt_reg   <= CNT_W'(WARM_N);
                            state_reg <= ST_WARM_MUL;
                        end
                    end
                end
                ST_WARM_MUL:
                begin
                    state_reg <= ST_WARM_RED;
                end
                ST_WARM_RED:
                begin
                    g1_reg <= g1_next;
                    if (cnt_reg == '0)
                    begin
                        last_draw_reg <= g1_next;
                        warmed_reg    <= 1'b1;
                        state_reg     <= ST_G1;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= ST_WARM_MUL;
                    end
                end
                ST_G1:
                begin
                    state_reg <= ST_G2;
                end
                ST_G2:
                begin
                    g1_reg    <= g1_next;
                    state_reg <= ST_SLOT;
                end
                ST_SLOT:
                begin
                    g2_reg    <= g2_next;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_DRAW;
                end
                ST_DRAW:
                begin
                    last_draw_reg <= draw_next;
                    neg_reg       <= span[32];
                    mag_reg       <= span_abs[31:0];
                    state_reg     <= ST_FRAC;
                end
                ST_FRAC:
                begin
                    frac_reg  <= sclu_pkg::draw_fraction(last_draw_reg);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {1'b0, last_draw_reg, res_sat};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
